### hw/rtl/wtss_pkg.sv
// ----------------------------------------------------------------------------
// wtss_pkg: shared types and constants for the word timestamp snapper
// Item structs, op and status codes, config indexes, controller commands.
// ----------------------------------------------------------------------------
package wtss_pkg;

  localparam int REGION_DEPTH = 256;
  localparam int ADDR_W = (REGION_DEPTH > 1) ? $clog2(REGION_DEPTH) : 1;
  localparam int CNT_W = $clog2(REGION_DEPTH + 1);
  localparam int TIME_W = 32;
  localparam int CFG_W = 16;
  localparam int CFG_IDX_W = 1;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;

  localparam logic [1:0] ST_WORD    = 2'd0;
  localparam logic [1:0] ST_STORED  = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;
  localparam logic [1:0] ST_CLEARED = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WORD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SNAP = 1'd1;

  typedef struct packed {
    logic [1:0]        op;
    logic [TIME_W-1:0] time_start;
    logic [TIME_W-1:0] time_end;
    logic              first_in_segment;
    logic              last_in_segment;
  } item_in_t;

  typedef struct packed {
    logic [TIME_W-1:0] new_start;
    logic [TIME_W-1:0] new_end;
    logic              changed;
    logic [1:0]        status;
  } item_out_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_DISP,
    CMD_READ,
    CMD_EVAL,
    CMD_FIXA,
    CMD_FIXB,
    CMD_FIXC,
    CMD_FINW,
    CMD_OUT
  } cmd_t;

  typedef struct packed {
    logic done_early;  // table op or word left unchanged at dispatch
    logic more;        // walk index below region count
    logic ev_again;    // scan found the first region, evaluate it again
    logic ev_stop;     // walk ends
    logic fix_skip;    // word already long enough
    logic fix_c;       // centered fix needs its last step
    logic out_free;    // output register can take a result
  } ctl_sts_t;

endpackage

### hw/rtl/wtss_ctrl.sv
// ----------------------------------------------------------------------------
// wtss_ctrl: sequencer for the word timestamp snapper
// One-hot state machine: one datapath command per cycle unless idle or held.
// ----------------------------------------------------------------------------
module wtss_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  wtss_pkg::ctl_sts_t sts,
  output wtss_pkg::cmd_t    cmd
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DISP = 9'b000000010,
    S_READ = 9'b000000100,
    S_EVAL = 9'b000001000,
    S_FIXA = 9'b000010000,
    S_FIXB = 9'b000100000,
    S_FIXC = 9'b001000000,
    S_FINW = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd = wtss_pkg::CMD_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd = wtss_pkg::CMD_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        cmd = wtss_pkg::CMD_DISP;
        state_next = sts.done_early ? S_OUT : S_READ;
      end
      S_READ: begin
        cmd = wtss_pkg::CMD_READ;
        state_next = sts.more ? S_EVAL : S_FIXA;
      end
      S_EVAL: begin
        cmd = wtss_pkg::CMD_EVAL;
        if (sts.ev_again) begin
          state_next = S_EVAL;
        end else if (sts.ev_stop) begin
          state_next = S_FIXA;
        end else begin
          state_next = S_READ;
        end
      end
      S_FIXA: begin
        cmd = wtss_pkg::CMD_FIXA;
        state_next = sts.fix_skip ? S_FINW : S_FIXB;
      end
      S_FIXB: begin
        cmd = wtss_pkg::CMD_FIXB;
        state_next = sts.fix_c ? S_FIXC : S_FINW;
      end
      S_FIXC: begin
        cmd = wtss_pkg::CMD_FIXC;
        state_next = S_FINW;
      end
      S_FINW: begin
        cmd = wtss_pkg::CMD_FINW;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (sts.out_free) begin
          cmd = wtss_pkg::CMD_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/wtss_dpath.sv
// ----------------------------------------------------------------------------
// wtss_dpath: datapath of the word timestamp snapper
// Region memory, walk registers, duration fix-up and output register.
// ----------------------------------------------------------------------------
module wtss_dpath (
  input  logic                                clk,
  input  logic                                rst,
  input  wtss_pkg::cmd_t                      cmd,
  output wtss_pkg::ctl_sts_t                  sts,
  input  wtss_pkg::item_in_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output wtss_pkg::item_out_t                 out_data,
  input  logic                                cfg_wr_en,
  input  logic [wtss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [wtss_pkg::CFG_W-1:0]          cfg_data
);

  localparam int TW = wtss_pkg::TIME_W;
  localparam int AW = wtss_pkg::ADDR_W;
  localparam int CW = wtss_pkg::CNT_W;
  localparam int FW = wtss_pkg::CFG_W;

  typedef struct packed {
    logic [TW-1:0] r_start;
    logic [TW-1:0] r_finish;
  } region_t;

  typedef enum logic [1:0] {
    MODE_S,
    MODE_E,
    MODE_MID,
    MODE_KEEP
  } fix_mode_t;

  region_t mem [wtss_pkg::REGION_DEPTH];
  region_t rd;

  logic [FW-1:0] min_word;
  logic [FW-1:0] min_snap;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  wtss_pkg::item_in_t item;
  logic [TW-1:0] ns;
  logic [TW-1:0] ne;
  logic          mv_s;
  logic          mv_e;
  logic          walk;
  fix_mode_t     mode;
  wtss_pkg::item_out_t res;

  logic [TW-1:0] t0;
  logic [TW-1:0] t1;
  logic          is_word;
  logic          trivial;
  logic          table_full;

  logic [TW:0]   mind33;
  logic [TW:0]   sum_ns;
  logic          short_w;
  logic [TW:0]   sum_tt;
  logic          long_w;
  logic [TW:0]   diff_e;
  logic          e_above;
  logic [TW-1:0] sat_sum;

  logic          scan_hit;
  logic          region_short;
  logic          below_end;
  logic          c1;
  logic          c2;
  logic          c3;
  logic [TW-1:0] gap_l;
  logic [TW-1:0] gap_r;
  logic          take_start;

  assign t0 = item.time_start;
  assign t1 = item.time_end;
  assign is_word = item.op[1];
  assign trivial = (count == '0) || (t0 >= t1);
  assign table_full = (count == CW'(wtss_pkg::REGION_DEPTH));

  assign mind33 = {{(TW+1-FW){1'b0}}, min_word};
  assign sum_ns = {1'b0, ns} + mind33;
  assign short_w = {1'b0, ne} < sum_ns;
  assign sum_tt = {1'b0, t0} + {1'b0, t1};
  assign long_w = {1'b0, t1} >= ({1'b0, t0} + mind33);
  assign diff_e = {1'b0, ne} - mind33;
  assign e_above = ({1'b0, ne} >= mind33) && (diff_e[TW-1:0] > t0);
  assign sat_sum = sum_ns[TW] ? {TW{1'b1}} : sum_ns[TW-1:0];

  assign scan_hit = rd.r_finish > t0;
  assign region_short = {1'b0, rd.r_finish} <
                        ({1'b0, rd.r_start} + {{(TW+1-FW){1'b0}}, min_snap});
  assign below_end = rd.r_start < ne;
  assign c1 = (rd.r_start <= ns) && (rd.r_finish > ns) && (rd.r_finish <= ne);
  assign c2 = (rd.r_start >= ns) && (rd.r_start < ne) && (rd.r_finish >= ne);
  assign c3 = (rd.r_start > ns) && (rd.r_finish < ne);
  assign gap_l = rd.r_start - ns;
  assign gap_r = ne - rd.r_finish;
  assign take_start = item.first_in_segment ||
                      (!item.last_in_segment && (gap_l >= gap_r));

  always_comb begin
    sts.done_early = !is_word || trivial;
    sts.more = idx < count;
    sts.ev_again = !walk && scan_hit;
    sts.ev_stop = walk && (!below_end ||
                  (!region_short && !c1 && (c2 || (c3 && !take_start))));
    sts.fix_skip = !short_w;
    sts.fix_c = (mode == MODE_MID);
    sts.out_free = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      min_word <= '0;
      min_snap <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        wtss_pkg::CFG_MIN_WORD: min_word <= cfg_data;
        wtss_pkg::CFG_MIN_SNAP: min_snap <= cfg_data;
        default: ;
      endcase
    end
  end

  // region memory: one write port at append, one registered read port
  always_ff @(posedge clk) begin
    if (cmd == wtss_pkg::CMD_DISP && !is_word && item.op == wtss_pkg::OP_APPEND &&
        !table_full) begin
      mem[count[AW-1:0]] <= '{r_start: t0, r_finish: t1};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == wtss_pkg::CMD_READ) begin
      rd <= mem[idx[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd == wtss_pkg::CMD_DISP && !is_word) begin
      if (item.op == wtss_pkg::OP_CLEAR) begin
        count <= '0;
      end else if (!table_full) begin
        count <= count + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd)
      wtss_pkg::CMD_LOAD: begin
        item <= in_data;
      end
      wtss_pkg::CMD_DISP: begin
        ns <= t0;
        ne <= t1;
        mv_s <= 1'b0;
        mv_e <= 1'b0;
        walk <= 1'b0;
        idx <= '0;
        if (!is_word) begin
          res.new_start <= '0;
          res.new_end <= '0;
          res.changed <= 1'b0;
          if (item.op == wtss_pkg::OP_CLEAR) begin
            res.status <= wtss_pkg::ST_CLEARED;
          end else if (table_full) begin
            res.status <= wtss_pkg::ST_DROPPED;
          end else begin
            res.status <= wtss_pkg::ST_STORED;
          end
        end else begin
          res.new_start <= t0;
          res.new_end <= t1;
          res.changed <= 1'b0;
          res.status <= wtss_pkg::ST_WORD;
        end
      end
      wtss_pkg::CMD_EVAL: begin
        if (!walk) begin
          if (scan_hit) begin
            walk <= 1'b1;
          end else begin
            idx <= idx + CW'(1);
          end
        end else if (below_end) begin
          if (region_short) begin
            idx <= idx + CW'(1);
          end else if (c1) begin
            ns <= rd.r_finish;
            mv_s <= 1'b1;
            idx <= idx + CW'(1);
          end else if (c2) begin
            ne <= rd.r_start;
            mv_e <= 1'b1;
          end else if (c3) begin
            if (take_start) begin
              ns <= rd.r_finish;
              mv_s <= 1'b1;
              idx <= idx + CW'(1);
            end else begin
              ne <= rd.r_start;
              mv_e <= 1'b1;
            end
          end else begin
            idx <= idx + CW'(1);
          end
        end
      end
      wtss_pkg::CMD_FIXA: begin
        if (mv_s && !mv_e) begin
          mode <= MODE_S;
          if (short_w) begin
            ne <= (sum_ns < {1'b0, t1}) ? sum_ns[TW-1:0] : t1;
          end
        end else if (mv_e && !mv_s) begin
          mode <= MODE_E;
          if (short_w) begin
            ns <= e_above ? diff_e[TW-1:0] : t0;
          end
        end else if (long_w) begin
          mode <= MODE_MID;
          if (short_w) begin
            ns <= sum_tt[TW:1];
          end
        end else begin
          mode <= MODE_KEEP;
          if (short_w) begin
            ns <= t0;
            ne <= t1;
          end
        end
      end
      wtss_pkg::CMD_FIXB: begin
        case (mode)
          MODE_S: begin
            if (short_w) begin
              ns <= ({1'b0, ne} > mind33) ? (ne - TW'(min_word)) : '0;
            end
          end
          MODE_E: begin
            if (short_w) begin
              ne <= sat_sum;
            end
          end
          MODE_MID: begin
            ns <= ns - TW'(min_word[FW-1:1]);
          end
          default: ;
        endcase
      end
      wtss_pkg::CMD_FIXC: begin
        ne <= sat_sum;
      end
      wtss_pkg::CMD_FINW: begin
        if (ne > ns) begin
          res.new_start <= ns;
          res.new_end <= ne;
          res.changed <= 1'b1;
        end else begin
          res.new_start <= t0;
          res.new_end <= t1;
          res.changed <= 1'b0;
        end
        res.status <= wtss_pkg::ST_WORD;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd == wtss_pkg::CMD_OUT) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd == wtss_pkg::CMD_OUT) begin
      out_data <= res;
    end
  end

endmodule

### hw/rtl/word_timestamp_silence_snap.sv
// ----------------------------------------------------------------------------
// word_timestamp_silence_snap: snap word times out of silence regions
// Top level: sequencer, datapath and the block's own checks.
// ----------------------------------------------------------------------------
// Usage:
//   Input items on in_valid/in_ready carry an op: clear the region table,
//   append one silence region, or snap one word against the table.
//   Every item gives exactly one result item on out_valid/out_ready.
//   Regions live in a 256-entry memory with one write and one read port.
//   Table ops and words left as they are (empty table, end not after start)
//   go from dispatch straight to the output register. Other words walk the
//   table one region at a time, reading each region and then evaluating it,
//   evaluating again when the walk finds its first region, and then enforce
//   the minimum length before the result is loaded into the output register;
//   the next item can be accepted in the cycle that out_valid rises.
//   Config writes (cfg_wr_en, cfg_index, cfg_data) are registered and are
//   to be made while the block is idle; the block itself does not enforce it.
//   Reset empties the table and clears both config registers.
//   A stalled receiver holds the result in the output register; one more
//   item is accepted and worked, then waits until the register frees.
// ----------------------------------------------------------------------------
module word_timestamp_silence_snap (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  wtss_pkg::item_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output wtss_pkg::item_out_t              out_data,
  input  logic                             cfg_wr_en,
  input  logic [wtss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [wtss_pkg::CFG_W-1:0]       cfg_data
);

  wtss_pkg::cmd_t     cmd;
  wtss_pkg::ctl_sts_t sts;

  wtss_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  wtss_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("block ready right after taking an item");

  a_table_result_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.status != wtss_pkg::ST_WORD) |->
      (!out_data.changed && out_data.new_start == '0 && out_data.new_end == '0))
    else $error("table op result carries word fields");

  a_changed_ordered: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.changed) |-> (out_data.new_end > out_data.new_start))
    else $error("changed word is empty or inverted");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (cmd == wtss_pkg::CMD_OUT) |=> out_valid)
    else $error("result load did not raise out_valid");

endmodule

### tb/sv/tb_word_timestamp_silence_snap.sv
// ----------------------------------------------------------------------------
// tb_word_timestamp_silence_snap: self-checking bench for the silence snapper
// Loads silence tables and snaps words against them under random handshake
// gaps, checking each result against a cycle-free model of the snap rules.
// ----------------------------------------------------------------------------
module tb_word_timestamp_silence_snap;

  localparam logic [1:0] OP_SNAP     = 2'd2;
  localparam logic [1:0] OP_SNAP_ALT = 2'd3;
  localparam longint     TIME_TOP    = 64'h0000_0000_FFFF_FFFF;
  localparam int         QUIET_LIMIT = 10000;
  localparam int         WORD_ITEMS  = 870;

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           in_valid = 1'b0;
  logic                           in_ready;
  wtss_pkg::item_in_t             in_data = '0;
  logic                           out_valid;
  logic                           out_ready = 1'b0;
  wtss_pkg::item_out_t            out_data;
  logic                           cfg_wr_en = 1'b0;
  logic [wtss_pkg::CFG_IDX_W-1:0] cfg_index = wtss_pkg::CFG_MIN_WORD;
  logic [wtss_pkg::CFG_W-1:0]     cfg_data = '0;

  // model state
  logic [31:0] region_lo [wtss_pkg::REGION_DEPTH];
  logic [31:0] region_hi [wtss_pkg::REGION_DEPTH];
  int          region_total = 0;
  logic [15:0] min_word_q = '0;
  logic [15:0] min_snap_q = '0;

  wtss_pkg::item_in_t  feed_q [$];
  wtss_pkg::item_out_t due_q [$];
  logic [31:0]         gen_lo [$];
  logic [31:0]         gen_hi [$];

  wtss_pkg::item_out_t want;
  int  pushed = 0;
  int  err_cnt = 0;
  int  tx_gap = 0, rx_gap = 0, quiet = 0;
  bit  tx_idle_on = 1'b1, rx_idle_on = 1'b1;
  int  n_words = 0, n_snapped = 0, n_stored = 0, n_dropped = 0, n_cleared = 0;
  int  n_cfg = 0;

  word_timestamp_silence_snap uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic wtss_pkg::item_out_t snap_predict(wtss_pkg::item_in_t it);
    wtss_pkg::item_out_t r;
    longint    t0, t1, ns, ne, rs, re, mind, mins, mid;
    bit        mv_s, mv_e, take_start;
    int        k;
    r = '0;
    case (it.op)
      wtss_pkg::OP_CLEAR: begin
        region_total = 0;
        r.status = wtss_pkg::ST_CLEARED;
      end
      wtss_pkg::OP_APPEND: begin
        if (region_total < wtss_pkg::REGION_DEPTH) begin
          region_lo[region_total] = it.time_start;
          region_hi[region_total] = it.time_end;
          region_total++;
          r.status = wtss_pkg::ST_STORED;
        end else begin
          r.status = wtss_pkg::ST_DROPPED;
        end
      end
      default: begin
        r.status = wtss_pkg::ST_WORD;
        r.new_start = it.time_start;
        r.new_end = it.time_end;
        t0 = longint'(it.time_start);
        t1 = longint'(it.time_end);
        mind = longint'(min_word_q);
        mins = longint'(min_snap_q);
        if (region_total != 0 && t0 < t1) begin
          ns = t0;
          ne = t1;
          mv_s = 1'b0;
          mv_e = 1'b0;
          k = 0;
          while (k < region_total && longint'(region_hi[k]) <= t0) k++;
          for (; k < region_total && longint'(region_lo[k]) < ne; k++) begin
            rs = longint'(region_lo[k]);
            re = longint'(region_hi[k]);
            if (re - rs < mins) continue;
            if (rs <= ns && re > ns && re <= ne) begin
              ns = re;
              mv_s = 1'b1;
            end else if (rs >= ns && rs < ne && re >= ne) begin
              ne = rs;
              mv_e = 1'b1;
              break;
            end else if (rs > ns && re < ne) begin
              if (it.first_in_segment) take_start = 1'b1;
              else if (it.last_in_segment) take_start = 1'b0;
              else take_start = (rs - ns) >= (ne - re);
              if (take_start) begin
                ns = re;
                mv_s = 1'b1;
              end else begin
                ne = rs;
                mv_e = 1'b1;
                break;
              end
            end
          end
          if (ne - ns < mind) begin
            if (mv_s && !mv_e) begin
              ne = (ns + mind < t1) ? ns + mind : t1;
              if (ne - ns < mind) ns = (ne - mind > 0) ? ne - mind : 0;
            end else if (mv_e && !mv_s) begin
              ns = (ne - mind > t0) ? ne - mind : t0;
              if (ne - ns < mind) ne = (ns + mind > TIME_TOP) ? TIME_TOP : ns + mind;
            end else if (t1 - t0 >= mind) begin
              mid = (t0 + t1) / 2;
              ns = mid - mind / 2;
              ne = (ns + mind > TIME_TOP) ? TIME_TOP : ns + mind;
            end else begin
              ns = t0;
              ne = t1;
            end
          end
          if (ne > ns) begin
            r.new_start = ns[31:0];
            r.new_end = ne[31:0];
            r.changed = 1'b1;
          end
        end
      end
    endcase
    return r;
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) due_q.insert(due_q.size(), snap_predict(in_data));
      if (!in_valid || in_ready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (feed_q.size() > 0) begin
          in_data <= feed_q.pop_front();
          in_valid <= 1'b1;
          if (tx_idle_on && $urandom_range(0, 5) == 0) tx_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result start=%h end=%h changed=%b status=%0d",
                   $time, out_data.new_start, out_data.new_end, out_data.changed,
                   out_data.status);
        end else begin
          want = due_q.pop_front();
          if (out_data.new_start !== want.new_start || out_data.new_end !== want.new_end ||
              out_data.changed !== want.changed || out_data.status !== want.status) begin
            err_cnt++;
            $display("%0t: mismatch expected start=%h end=%h changed=%b status=%0d, %s",
                     $time, want.new_start, want.new_end, want.changed, want.status,
                     $sformatf("actual start=%h end=%h changed=%b status=%0d",
                               out_data.new_start, out_data.new_end, out_data.changed,
                               out_data.status));
          end
          case (want.status)
            wtss_pkg::ST_WORD: begin
              n_words++;
              if (want.changed) n_snapped++;
            end
            wtss_pkg::ST_STORED:  n_stored++;
            wtss_pkg::ST_DROPPED: n_dropped++;
            default:              n_cleared++;
          endcase
        end
      end
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (rx_idle_on && $urandom_range(0, 7) == 0) rx_gap = $urandom_range(1, 18);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                 $time, QUIET_LIMIT, due_q.size());
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic push_item(input logic [1:0] op, input logic [31:0] ts, te,
                           input logic fs, ls);
    wtss_pkg::item_in_t it;
    it.op = op;
    it.time_start = ts;
    it.time_end = te;
    it.first_in_segment = fs;
    it.last_in_segment = ls;
    feed_q.insert(feed_q.size(), it);
    pushed++;
    if (op == wtss_pkg::OP_CLEAR) begin
      gen_lo.delete();
      gen_hi.delete();
    end else if (op == wtss_pkg::OP_APPEND && gen_lo.size() < wtss_pkg::REGION_DEPTH) begin
      gen_lo.insert(gen_lo.size(), ts);
      gen_hi.insert(gen_hi.size(), te);
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (feed_q.size() != 0 || in_valid || due_q.size() != 0) @(negedge clk);
  endtask

  task automatic apply_cfg(input logic [15:0] mw, input logic [15:0] ms);
    wait_drained();
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= wtss_pkg::CFG_MIN_WORD;
    cfg_data <= mw;
    @(posedge clk);
    cfg_index <= wtss_pkg::CFG_MIN_SNAP;
    cfg_data <= ms;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    min_word_q = mw;
    min_snap_q = ms;
    n_cfg++;
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_len();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(0, 200));
    endcase
  endfunction

  // words anchored near boundaries of the regions loaded so far, or random while there are none
  task automatic push_word();
    logic [31:0] a, b, t;
    int          j, k;
    if (gen_lo.size() == 0) begin
      a = $urandom;
      b = a + $urandom_range(1, 400);
    end else begin
      j = $urandom_range(0, gen_lo.size() - 1);
      k = j + $urandom_range(0, 2);
      if (k >= gen_lo.size()) k = gen_lo.size() - 1;
      a = ($urandom_range(0, 1) ? gen_lo[j] : gen_hi[j]) + $urandom_range(0, 60) - 30;
      b = ($urandom_range(0, 1) ? gen_lo[k] : gen_hi[k]) + $urandom_range(0, 60) - 30;
      if ($urandom_range(0, 3) == 0) b = a + $urandom_range(0, 500);
    end
    if (a > b && $urandom_range(0, 15) != 0) begin
      t = a;
      a = b;
      b = t;
    end
    push_item(($urandom_range(0, 7) == 0) ? OP_SNAP_ALT : OP_SNAP, a, b,
              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
  endtask

  // mostly sorted regions; some inverted, some out of order, some long
  task automatic push_regions(input int n);
    logic [31:0] cur, len;
    case ($urandom_range(0, 3))
      0:       cur = $urandom_range(0, 400);
      1:       cur = 32'hFFFF_0000 + $urandom_range(0, 16'hE000);
      default: cur = $urandom;
    endcase
    repeat (n) begin
      cur = cur + $urandom_range(0, 120);
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 80000) : $urandom_range(0, 150);
      case ($urandom_range(0, 11))
        0:       push_item(wtss_pkg::OP_APPEND, cur + len, cur, 1'b0, 1'b1);
        1:       push_item(wtss_pkg::OP_APPEND, cur - $urandom_range(200, 2000), cur - 150,
                           1'b1, 1'b0);
        default: push_item(wtss_pkg::OP_APPEND, cur, cur + len,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      endcase
      cur = cur + len;
    end
  endtask

  task automatic run_phase();
    apply_cfg(pick_len(), pick_len());
    if ($urandom_range(0, 9) != 0)
      push_item(wtss_pkg::OP_CLEAR, $urandom, $urandom, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 1)));
    push_regions($urandom_range(1, 10));
    repeat ($urandom_range(5, 18)) begin
      case ($urandom_range(0, 19))
        0:       push_item(2'($urandom_range(0, 3)), $urandom, $urandom,
                           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        1:       push_regions(1);
        default: push_word();
      endcase
    end
  endtask

  initial begin
    logic [31:0] cur;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // reset config: no minimum length, every region counts unless it ends before it starts
    push_item(OP_SNAP, 10, 20, 1'b0, 1'b0);
    push_item(wtss_pkg::OP_CLEAR, 0, 0, 1'b0, 1'b0);
    push_item(wtss_pkg::OP_APPEND, 100, 200, 1'b0, 1'b0);
    push_item(wtss_pkg::OP_APPEND, 300, 350, 1'b0, 1'b0);
    push_item(wtss_pkg::OP_APPEND, 500, 450, 1'b0, 1'b0);
    push_item(wtss_pkg::OP_APPEND, 32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1, 1'b1);
    push_item(OP_SNAP, 150, 400, 1'b0, 1'b0);
    push_item(OP_SNAP, 50, 120, 1'b0, 1'b0);
    push_item(OP_SNAP, 50, 250, 1'b1, 1'b0);
    push_item(OP_SNAP, 50, 250, 1'b0, 1'b1);
    push_item(OP_SNAP_ALT, 60, 260, 1'b0, 1'b0);
    push_item(OP_SNAP, 400, 300, 1'b0, 1'b0);
    push_item(OP_SNAP, 0, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // longest word minimum: end saturation, one-sided and centered fixes
    apply_cfg(16'hFFFF, 16'd60);
    push_item(OP_SNAP, 32'hFFFF_FEF0, 32'hFFFF_FFFF, 1'b0, 0);
    push_item(OP_SNAP, 150, 400, 1'b1, 1'b0);
    push_item(OP_SNAP, 50, 120, 1'b0, 1'b0);
    push_item(OP_SNAP, 1000, 70000, 1'b0, 1'b0);
    push_item(OP_SNAP, 1000, 1100, 1'b0, 1'b1);
    // only very long silences count
    apply_cfg(16'd10, 16'hFFFF);
    push_item(OP_SNAP, 150, 400, 1'b0, 1'b0);
    push_item(wtss_pkg::OP_APPEND, 0, 32'h0001_0000, 1'b0, 1'b0);
    push_item(OP_SNAP, 10, 70000, 1'b0, 1'b1);

    while (pushed < 300) run_phase();

    // full table, overflow appends, long walks
    apply_cfg(16'($urandom_range(0, 40)), 16'($urandom_range(0, 20)));
    push_item(wtss_pkg::OP_CLEAR, 0, 0, 1'b0, 1'b0);
    cur = $urandom_range(0, 1000);
    repeat (wtss_pkg::REGION_DEPTH + 2) begin
      cur = cur + $urandom_range(0, 40);
      push_item(wtss_pkg::OP_APPEND, cur, cur + $urandom_range(5, 30), 1'b0, 1'b0);
      cur = cur + 30;
    end
    repeat (10) push_word();

    while (pushed < WORD_ITEMS - 100) begin
      tx_idle_on = ($urandom_range(0, 3) != 0);
      rx_idle_on = ($urandom_range(0, 3) != 0);
      run_phase();
    end
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    while (pushed < WORD_ITEMS) run_phase();

    wait_drained();
    repeat (40) @(posedge clk);
    $display("Covered %0d words (%0d snapped), %0d regions stored, %0d dropped,",
             n_words, n_snapped, n_stored, n_dropped);
    $display("%0d table clears and %0d register settings; %0d errors",
             n_cleared, n_cfg, err_cnt);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### sim.f
hw/rtl/wtss_pkg.sv
hw/rtl/wtss_ctrl.sv
hw/rtl/wtss_dpath.sv
hw/rtl/word_timestamp_silence_snap.sv
tb/sv/tb_word_timestamp_silence_snap.sv
